/* design/orc_pkg.sv */
// ----------------------------------------------------------------------------
// orc_pkg
// Shared constants, types and the arctangent table for the oriented
// rectangle corners unit.
// ----------------------------------------------------------------------------
package orc_pkg;

	// angle and fraction precision of the sine/cosine path
	localparam int ANGLE_BITS    = 16;
	localparam int FRACTION_BITS = 16;

	localparam int CoordW    = 32;
	localparam int HeadingW  = 16;
	localparam int LenW      = 24;
	localparam int CfgIndexW = 8;
	localparam int CfgDataW  = 32;

	// cordic datapath widths
	localparam int TrigW = FRACTION_BITS + 3;
	localparam int ZW    = 33;

	localparam int StepsPerStage = 2;
	localparam int CordicStages  = (FRACTION_BITS + StepsPerStage - 1) / StepsPerStage;
	localparam int SincosLatency = CordicStages + 1;
	localparam int CornerLatency = 2;
	localparam int TotalLatency  = 1 + SincosLatency + CornerLatency;

	// cordic gain in Q30, rounded half up to Q(FRACTION_BITS)
	localparam longint GainQ30 = 64'sd652032874;
	localparam longint CordicK =
		(GainQ30 + (64'sd1 <<< (29 - FRACTION_BITS))) >>> (30 - FRACTION_BITS);

	localparam logic [31:0] AngleMask = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

	// register indexes
	localparam logic [CfgIndexW-1:0] RegBodyLength = CfgIndexW'(0);
	localparam logic [CfgIndexW-1:0] RegBodyWidth  = CfgIndexW'(1);

	typedef logic signed [TrigW-1:0]  trig_t;
	typedef logic signed [ZW-1:0]     angle_t;
	typedef logic signed [CoordW-1:0] coord_t;

	typedef struct packed {
		coord_t fl_x;
		coord_t fl_y;
		coord_t fr_x;
		coord_t fr_y;
		coord_t rr_x;
		coord_t rr_y;
		coord_t rl_x;
		coord_t rl_y;
	} corners_t;

	// arctangent of 2^-idx in 2^-32 turn units
	function automatic angle_t atan_turn(input int idx);
		case (idx)
			0:       return 33'sd536870912;
			1:       return 33'sd316933406;
			2:       return 33'sd167458907;
			3:       return 33'sd85004756;
			4:       return 33'sd42667331;
			5:       return 33'sd21354465;
			6:       return 33'sd10679838;
			7:       return 33'sd5340245;
			8:       return 33'sd2670163;
			9:       return 33'sd1335087;
			10:      return 33'sd667544;
			11:      return 33'sd333772;
			12:      return 33'sd166886;
			13:      return 33'sd83443;
			14:      return 33'sd41722;
			15:      return 33'sd20861;
			16:      return 33'sd10430;
			17:      return 33'sd5215;
			18:      return 33'sd2608;
			19:      return 33'sd1304;
			20:      return 33'sd652;
			21:      return 33'sd326;
			22:      return 33'sd163;
			23:      return 33'sd81;
			default: return '0;
		endcase
	endfunction

endpackage

/* design/orc_sincos.sv */
// ----------------------------------------------------------------------------
// orc_sincos
// Pipelined cordic: quadrant fold, two rotations per stage, sign fix-up.
// ----------------------------------------------------------------------------
module orc_sincos import orc_pkg::*; (
	input  logic                       clk,
	input  logic signed [HeadingW-1:0] heading,
	output trig_t                      cos_val,
	output trig_t                      sin_val
);

	logic [31:0] turn;
	logic        flip_in;
	angle_t      z_in;

	trig_t  x_src [CordicStages];
	trig_t  y_src [CordicStages];
	angle_t z_src [CordicStages];
	logic   f_src [CordicStages];

	trig_t  x_nxt [CordicStages];
	trig_t  y_nxt [CordicStages];
	angle_t z_nxt [CordicStages];

	trig_t  x_s [CordicStages];
	trig_t  y_s [CordicStages];
	angle_t z_s [CordicStages];
	logic   f_s [CordicStages];

	trig_t cos_q;
	trig_t sin_q;

	// fold second and third quadrants by half a turn
	assign turn    = {heading, 16'b0} & AngleMask;
	assign flip_in = turn[31] ^ turn[30];
	assign z_in    = {turn[31] ^ flip_in, turn[31] ^ flip_in, turn[30:0]};

	always_comb begin
		x_src[0] = TrigW'(CordicK);
		y_src[0] = '0;
		z_src[0] = z_in;
		f_src[0] = flip_in;
		for (int k = 1; k < CordicStages; k++) begin
			x_src[k] = x_s[k-1];
			y_src[k] = y_s[k-1];
			z_src[k] = z_s[k-1];
			f_src[k] = f_s[k-1];
		end
	end

	always_comb begin
		trig_t  xv;
		trig_t  yv;
		trig_t  dx;
		trig_t  dy;
		angle_t zv;
		int     i;
		for (int k = 0; k < CordicStages; k++) begin
			xv = x_src[k];
			yv = y_src[k];
			zv = z_src[k];
			for (int j = 0; j < StepsPerStage; j++) begin
				i = k * StepsPerStage + j;
				if (i < FRACTION_BITS) begin
					dx = yv >>> i;
					dy = xv >>> i;
					if (!zv[ZW-1]) begin
						xv = xv - dx;
						yv = yv + dy;
						zv = zv - atan_turn(i);
					end else begin
						xv = xv + dx;
						yv = yv - dy;
						zv = zv + atan_turn(i);
					end
				end
			end
			x_nxt[k] = xv;
			y_nxt[k] = yv;
			z_nxt[k] = zv;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < CordicStages; k++) begin
			x_s[k] <= x_nxt[k];
			y_s[k] <= y_nxt[k];
			z_s[k] <= z_nxt[k];
			f_s[k] <= f_src[k];
		end
		cos_q <= f_s[CordicStages-1] ? -x_s[CordicStages-1] : x_s[CordicStages-1];
		sin_q <= f_s[CordicStages-1] ? -y_s[CordicStages-1] : y_s[CordicStages-1];
	end

	assign cos_val = cos_q;
	assign sin_val = sin_q;

endmodule

/* design/orc_corner_calc.sv */
// ----------------------------------------------------------------------------
// orc_corner_calc
// Half-size products with rounding, then corner sums with saturation.
// ----------------------------------------------------------------------------
module orc_corner_calc import orc_pkg::*; (
	input  logic            clk,
	input  trig_t           cos_val,
	input  trig_t           sin_val,
	input  logic [LenW-1:0] body_length,
	input  logic [LenW-1:0] body_width,
	input  coord_t          pose_x,
	input  coord_t          pose_y,
	output corners_t        corners
);

	localparam int ProdW = LenW + 1 + TrigW;
	localparam int TermW = ProdW - FRACTION_BITS - 1;
	localparam int SumW  = CoordW + 2;

	localparam logic signed [SumW-1:0] SatHi =
		{{(SumW - CoordW + 1){1'b0}}, {(CoordW - 1){1'b1}}};
	localparam logic signed [SumW-1:0] SatLo = ~SatHi;

	typedef logic signed [TermW-1:0] term_t;
	typedef logic signed [SumW-1:0]  sum_t;

	// len * trig / 2^(F+1), round to nearest, ties up
	function automatic term_t half_prod(input logic [LenW-1:0] len, input trig_t trig);
		logic signed [ProdW-1:0] p;
		p = $signed({1'b0, len}) * trig;
		p = p + (ProdW'(1) <<< FRACTION_BITS);
		return TermW'(p >>> (FRACTION_BITS + 1));
	endfunction

	function automatic coord_t sat(input sum_t v);
		if (v > SatHi)
			return CoordW'(SatHi);
		else if (v < SatLo)
			return CoordW'(SatLo);
		else
			return CoordW'(v);
	endfunction

	term_t  a_s1;
	term_t  b_s1;
	term_t  c_s1;
	term_t  d_s1;
	coord_t pose_x_s1;
	coord_t pose_y_s1;

	sum_t px;
	sum_t py;
	sum_t a;
	sum_t b;
	sum_t c;
	sum_t d;

	corners_t corners_nxt;
	corners_t corners_s2;

	always_ff @(posedge clk) begin
		a_s1      <= half_prod(body_length, cos_val);
		b_s1      <= half_prod(body_width, sin_val);
		c_s1      <= half_prod(body_width, cos_val);
		d_s1      <= half_prod(body_length, sin_val);
		pose_x_s1 <= pose_x;
		pose_y_s1 <= pose_y;
	end

	assign px = SumW'(pose_x_s1);
	assign py = SumW'(pose_y_s1);
	assign a  = SumW'(a_s1);
	assign b  = SumW'(b_s1);
	assign c  = SumW'(c_s1);
	assign d  = SumW'(d_s1);

	always_comb begin
		corners_nxt.fl_x = sat(px + a - b);
		corners_nxt.fl_y = sat(py + c + d);
		corners_nxt.fr_x = sat(px + a + b);
		corners_nxt.fr_y = sat(py - c + d);
		corners_nxt.rr_x = sat(px - a + b);
		corners_nxt.rr_y = sat(py - c - d);
		corners_nxt.rl_x = sat(px - a - b);
		corners_nxt.rl_y = sat(py + c - d);
	end

	always_ff @(posedge clk) begin
		corners_s2 <= corners_nxt;
	end

	assign corners = corners_s2;

endmodule

/* design/oriented_rectangle_corners_unit.sv */
// ----------------------------------------------------------------------------
// oriented_rectangle_corners_unit
// Four corners of a vehicle footprint from a pose and the configured size.
// ----------------------------------------------------------------------------
//
// channel  | handshake                    | payload
// ---------+------------------------------+-----------------------------------
// command  | start / busy                 | pose_x, pose_y, heading
// result   | done (one-cycle strobe)      | corner x/y ports, corner_heading
// config   | cfg_valid / cfg_ready        | cfg_index, cfg_data
//
// one transaction per cycle is taken; busy never rises
// from accept to done a transaction passes the input register, eight cordic
// stages of two rotations each, sign fix-up, product stage, sum stage
// arst_n clears the valid pipeline and both size registers
// results cannot be held off, so nothing in the pipeline ever stalls
// size registers may only change while no transaction is in flight
//
module oriented_rectangle_corners_unit import orc_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	// command channel
	input  logic                        start,
	output logic                        busy,
	input  logic signed [CoordW-1:0]    pose_x,
	input  logic signed [CoordW-1:0]    pose_y,
	input  logic signed [HeadingW-1:0]  heading,
	// result channel
	output logic                        done,
	output logic signed [CoordW-1:0]    front_left_x,
	output logic signed [CoordW-1:0]    front_left_y,
	output logic signed [CoordW-1:0]    front_right_x,
	output logic signed [CoordW-1:0]    front_right_y,
	output logic signed [CoordW-1:0]    rear_right_x,
	output logic signed [CoordW-1:0]    rear_right_y,
	output logic signed [CoordW-1:0]    rear_left_x,
	output logic signed [CoordW-1:0]    rear_left_y,
	output logic signed [HeadingW-1:0]  corner_heading,
	// configuration channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CfgIndexW-1:0]        cfg_index,
	input  logic [CfgDataW-1:0]         cfg_data
);

	logic accept;

	// size registers
	logic [LenW-1:0] body_length_q;
	logic [LenW-1:0] body_width_q;

	// valid bit for every stage from input register to result register
	logic [TotalLatency-1:0] vld_q;

	// input register
	coord_t                     pose_x_s1;
	coord_t                     pose_y_s1;
	logic signed [HeadingW-1:0] heading_s1;

	// pose follows the cordic, heading follows the whole pipeline
	coord_t                     pose_x_dly_q  [SincosLatency];
	coord_t                     pose_y_dly_q  [SincosLatency];
	logic signed [HeadingW-1:0] heading_dly_q [TotalLatency-1];

	trig_t    cos_val;
	trig_t    sin_val;
	corners_t corners;

	// every cycle is free for a new command and a config write
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_length_q <= '0;
			body_width_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				RegBodyLength: body_length_q <= cfg_data[LenW-1:0];
				RegBodyWidth:  body_width_q  <= cfg_data[LenW-1:0];
				default:       ; // unknown index, write dropped
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[TotalLatency-2:0], accept};
		end
	end

	// payload side needs no reset, the valid pipeline qualifies it
	always_ff @(posedge clk) begin
		pose_x_s1  <= pose_x;
		pose_y_s1  <= pose_y;
		heading_s1 <= heading;
		pose_x_dly_q[0]  <= pose_x_s1;
		pose_y_dly_q[0]  <= pose_y_s1;
		heading_dly_q[0] <= heading_s1;
		for (int k = 1; k < SincosLatency; k++) begin
			pose_x_dly_q[k] <= pose_x_dly_q[k-1];
			pose_y_dly_q[k] <= pose_y_dly_q[k-1];
		end
		for (int k = 1; k < TotalLatency - 1; k++) begin
			heading_dly_q[k] <= heading_dly_q[k-1];
		end
	end

	orc_sincos u_sincos (
		.clk     (clk),
		.heading (heading_s1),
		.cos_val (cos_val),
		.sin_val (sin_val)
	);

	orc_corner_calc u_corner_calc (
		.clk         (clk),
		.cos_val     (cos_val),
		.sin_val     (sin_val),
		.body_length (body_length_q),
		.body_width  (body_width_q),
		.pose_x      (pose_x_dly_q[SincosLatency-1]),
		.pose_y      (pose_y_dly_q[SincosLatency-1]),
		.corners     (corners)
	);

	assign done           = vld_q[TotalLatency-1];
	assign front_left_x   = corners.fl_x;
	assign front_left_y   = corners.fl_y;
	assign front_right_x  = corners.fr_x;
	assign front_right_y  = corners.fr_y;
	assign rear_right_x   = corners.rr_x;
	assign rear_right_y   = corners.rr_y;
	assign rear_left_x    = corners.rl_x;
	assign rear_left_y    = corners.rl_y;
	assign corner_heading = heading_dly_q[TotalLatency-2];

	// a result strobe always traces back to an accepted command
	a_done_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, TotalLatency))
		else $error("done without a matching accepted transaction");

	// heading leaves with the corners of the same transaction
	a_heading_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> corner_heading == $past(heading, TotalLatency))
		else $error("corner_heading out of step with its transaction");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for oriented_rectangle_corners_unit: poses go in on the
// start/busy channel, each accepted pose is run through a bit-exact corner
// predictor, and every done strobe is compared field by field in order.
// ----------------------------------------------------------------------------
module tb import orc_pkg::*; ();

	// ------------------------------------------------------------------------
	// predictor constants
	// ------------------------------------------------------------------------

	// rotation gain in Q30, rounded half up to the trig fraction width
	localparam longint RotGainQ30 = 64'sd652032874;
	localparam longint RotGain =
		(RotGainQ30 + (64'sd1 <<< (29 - FRACTION_BITS))) >>> (30 - FRACTION_BITS);

	// arctangent of 2^-i in 2^-32 turn units
	localparam longint AtanTurn [0:23] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	// an index with no register behind it, the top of the index range
	localparam logic [CfgIndexW-1:0] RegUnmapped = '1;

	typedef struct {
		coord_t                     x;
		coord_t                     y;
		logic signed [HeadingW-1:0] hdg;
	} pose_t;

	typedef struct {
		corners_t                   c;
		logic signed [HeadingW-1:0] hdg;
	} corner_set_t;

	// ------------------------------------------------------------------------
	// signals
	// ------------------------------------------------------------------------
	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic signed [CoordW-1:0]   pose_x;
	logic signed [CoordW-1:0]   pose_y;
	logic signed [HeadingW-1:0] heading;
	logic                       done;
	logic signed [CoordW-1:0]   front_left_x;
	logic signed [CoordW-1:0]   front_left_y;
	logic signed [CoordW-1:0]   front_right_x;
	logic signed [CoordW-1:0]   front_right_y;
	logic signed [CoordW-1:0]   rear_right_x;
	logic signed [CoordW-1:0]   rear_right_y;
	logic signed [CoordW-1:0]   rear_left_x;
	logic signed [CoordW-1:0]   rear_left_y;
	logic signed [HeadingW-1:0] corner_heading;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CfgIndexW-1:0]       cfg_index;
	logic [CfgDataW-1:0]        cfg_data;

	// bench state
	pose_t          pending_poses[$];     // poses not yet offered to the block
	corner_set_t    expected_corners[$];  // predictions awaiting a done strobe
	pose_t          pose_on_port;         // pose currently held on the command port
	logic [LenW-1:0] footprint_length;    // mirror of the size registers
	logic [LenW-1:0] footprint_width;
	int             send_idle_pct;
	int             mismatch_count;

	oriented_rectangle_corners_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.pose_x         (pose_x),
		.pose_y         (pose_y),
		.heading        (heading),
		.done           (done),
		.front_left_x   (front_left_x),
		.front_left_y   (front_left_y),
		.front_right_x  (front_right_x),
		.front_right_y  (front_right_y),
		.rear_right_x   (rear_right_x),
		.rear_right_y   (rear_right_y),
		.rear_left_x    (rear_left_x),
		.rear_left_y    (rear_left_y),
		.corner_heading (corner_heading),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// corner predictor
	// ------------------------------------------------------------------------

	// size times trig, halved and brought back to Q16.16, ties toward +inf
	function automatic longint half_term(input longint len, input longint trig);
		return (len * trig + (64'sd1 <<< FRACTION_BITS)) >>> (FRACTION_BITS + 1);
	endfunction

	function automatic coord_t clamp_coord(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'sh8000_0000;
		return coord_t'(v);
	endfunction

	function automatic corner_set_t predict_corners(input pose_t p);
		logic [31:0] turn;
		logic        flip;
		longint      cos_v, sin_v, z, dx, dy, a, b, c, d, px, py, hl_len, hw_len;
		int          i;
		corner_set_t r;
		// heading as a 32 bit turn fraction, truncated to the angle precision
		turn = {p.hdg, 16'h0000} & AngleMask;
		// second and third quadrant: rotate by half a turn, negate at the end
		flip = (turn[31:30] == 2'd1) || (turn[31:30] == 2'd2);
		if (flip)
			turn = turn + 32'h8000_0000;
		z = longint'(signed'(turn));
		cos_v = RotGain;
		sin_v = 0;
		for (i = 0; i < FRACTION_BITS; i++) begin
			dx = sin_v >>> i;
			dy = cos_v >>> i;
			if (z >= 0) begin
				cos_v -= dx;
				sin_v += dy;
				z -= AtanTurn[i];
			end else begin
				cos_v += dx;
				sin_v -= dy;
				z += AtanTurn[i];
			end
		end
		if (flip) begin
			cos_v = -cos_v;
			sin_v = -sin_v;
		end
		hl_len = longint'(footprint_length);
		hw_len = longint'(footprint_width);
		a  = half_term(hl_len, cos_v);
		b  = half_term(hw_len, sin_v);
		c  = half_term(hw_len, cos_v);
		d  = half_term(hl_len, sin_v);
		px = longint'(p.x);
		py = longint'(p.y);
		r.c.fl_x = clamp_coord(px + a - b);
		r.c.fl_y = clamp_coord(py + c + d);
		r.c.fr_x = clamp_coord(px + a + b);
		r.c.fr_y = clamp_coord(py - c + d);
		r.c.rr_x = clamp_coord(px - a + b);
		r.c.rr_y = clamp_coord(py - c - d);
		r.c.rl_x = clamp_coord(px - a - b);
		r.c.rl_y = clamp_coord(py + c - d);
		r.hdg = p.hdg;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// command driver: offers the next pending pose, holds it until taken
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		// a transaction completes on start high and busy low at this edge
		if (start && !busy)
			expected_corners.push_back(predict_corners(pose_on_port));
		// port is free once nothing is offered or the offer was just taken
		if (arst_n && (!start || !busy)) begin
			if (pending_poses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				pose_on_port = pending_poses.pop_front();
				start   <= 1'b1;
				pose_x  <= pose_on_port.x;
				pose_y  <= pose_on_port.y;
				heading <= pose_on_port.hdg;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// result monitor: each done strobe is matched against the oldest prediction
	// ------------------------------------------------------------------------
	function automatic void check_field(input string name,
			input logic signed [CoordW-1:0] want, input logic signed [CoordW-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin : result_monitor
		corner_set_t want;
		if (arst_n && done) begin
			if (expected_corners.size() == 0) begin
				$error("done strobe with no pose in flight");
				mismatch_count++;
			end else begin
				want = expected_corners.pop_front();
				check_field("front_left_x", want.c.fl_x, front_left_x);
				check_field("front_left_y", want.c.fl_y, front_left_y);
				check_field("front_right_x", want.c.fr_x, front_right_x);
				check_field("front_right_y", want.c.fr_y, front_right_y);
				check_field("rear_right_x", want.c.rr_x, rear_right_x);
				check_field("rear_right_y", want.c.rr_y, rear_right_y);
				check_field("rear_left_x", want.c.rl_x, rear_left_x);
				check_field("rear_left_y", want.c.rl_y, rear_left_y);
				check_field("corner_heading", want.hdg, corner_heading);
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	// one config transaction; the mirror follows the decode of the block
	task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == RegBodyLength)
			footprint_length = val[LenW-1:0];
		else if (idx == RegBodyWidth)
			footprint_width = val[LenW-1:0];
	endtask

	// block is idle once every pose is offered, taken and answered;
	// checked mid-cycle so the edge updates of driver and monitor have settled
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_poses.size() != 0 || start || expected_corners.size() != 0);
	endtask

	// mix of full range, values near zero and values near either end
	function automatic coord_t rand_coord();
		case ($urandom_range(3))
			0:       return coord_t'($urandom);
			1:       return coord_t'($urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000);
			2:       return coord_t'(32'h7FFF_FFFF - $urandom_range(0, 32'h00FF_FFFF));
			default: return coord_t'(32'h8000_0000 + $urandom_range(0, 32'h00FF_FFFF));
		endcase
	endfunction

	// new size, a stray write to an unmapped index, then a batch of random poses
	task automatic run_phase(input logic [CfgDataW-1:0] len_word,
			input logic [CfgDataW-1:0] wid_word, input int idle_pct, input int count);
		pose_t p;
		// sender holds off until every outstanding result is back
		wait_drained();
		write_reg(RegBodyLength, len_word);
		write_reg(RegBodyWidth, wid_word);
		write_reg(CfgIndexW'($urandom_range(int'(RegBodyWidth) + 1, (1 << CfgIndexW) - 1)),
			$urandom);
		send_idle_pct = idle_pct;
		repeat (count) begin
			p.x = rand_coord();
			p.y = rand_coord();
			// half the headings land close to a quadrant boundary
			if ($urandom_range(1))
				p.hdg = HeadingW'($urandom);
			else
				p.hdg = HeadingW'({$urandom_range(3), 14'd0} + $urandom_range(16) - 8);
			pending_poses.push_back(p);
		end
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		logic signed [HeadingW-1:0] sweep [0:11];
		clk            = 1'b0;
		arst_n         = 1'b0;
		start          = 1'b0;
		pose_x         = '0;
		pose_y         = '0;
		heading        = '0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		footprint_length = '0;
		footprint_width  = '0;
		send_idle_pct  = 0;
		mismatch_count = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// zero size out of reset: every corner sits on the pose itself
		pending_poses.push_back(pose_t'{32'sh0, 32'sh0, 16'sh0});
		pending_poses.push_back(pose_t'{32'sh7FFF_FFFF, 32'sh8000_0000, 16'sh7FFF});
		pending_poses.push_back(pose_t'{32'sh8000_0000, 32'sh7FFF_FFFF, 16'sh8000});
		wait_drained();

		// unmapped index must leave the size alone
		write_reg(RegUnmapped, 32'hFFFF_FFFF);
		// a car sized footprint: 4.5 m by 1.875 m
		write_reg(RegBodyLength, 32'h0004_8000);
		write_reg(RegBodyWidth, 32'h0001_E000);

		// heading sweep over axes, quadrant edges and both range ends
		sweep = '{16'sh0000, 16'sh0001, 16'sh2000, 16'sh3FFF, 16'sh4000, 16'sh4001,
			16'sh7FFF, 16'sh8000, 16'shBFFF, 16'shC000, 16'shC001, 16'shFFFF};
		foreach (sweep[k])
			pending_poses.push_back(pose_t'{32'sh0001_0000, 32'shFFFE_0000, sweep[k]});

		// corners pushed past either coordinate end saturate
		pending_poses.push_back(pose_t'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sh2000});
		pending_poses.push_back(pose_t'{32'sh8000_0000, 32'sh8000_0000, 16'sh2000});
		pending_poses.push_back(pose_t'{32'sh7FFF_8000, 32'sh8000_8000, 16'shA000});

		// random phases: sender back to back, mostly idle, back to back, a third idle
		run_phase({8'($urandom), 24'h04_8000}, {8'($urandom), 24'h01_E000}, 0, 100);
		run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 75, 100);
		run_phase({8'($urandom), 24'h00_0000}, {8'($urandom), 24'hFF_FFFF}, 0, 100);
		run_phase($urandom, $urandom, 34, 100);

		// drain, then give a stray strobe the full pipeline depth to show up
		wait_drained();
		repeat (TotalLatency + 4) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
